// ===== rtl/core/shabs_pkg.sv =====
// Constants and round functions for the SHA-256 byte stream hasher.
package shabs_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned HASH_WORDS  = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INITIAL_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/core/sha256_byte_stream_hasher_top.sv =====
// SHA-256 hasher over a byte stream: byte collection, padding, round sequencer, digest out.
//
// Usage
//   Input channel (in_valid/in_ready): each item may carry one message byte
//   (in_byte_present) and may close the message (in_message_end). A byte and
//   an end on the same item append the byte first.
//   Output channel (out_valid/out_ready): after each message end, eight items
//   carry the digest words, word 0 first, out_final_word set on word 7.
// Timing
//   Bytes are taken one per cycle while in_ready is high. The 64th byte of a
//   block starts one compression: a load step, 64 rounds on the single shared
//   round datapath and a fold into the running hash, all with in_ready low.
//   At message end the pad bytes are shifted in one per cycle (up to 64 per
//   block), then one or two compressions run, then the eight words are offered.
//   in_ready is low from message end until word 7 has been taken.
// Reset and stall
//   rst_n is synchronous, active low: hash words back to the initial values,
//   byte count and length cleared. A stalled receiver simply holds the
//   current digest word; nothing is lost. After word 7 the block returns to
//   the initial values and accepts the next message.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);
  import shabs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;       // bytes in the current block
  logic [60:0]  len_r, len_nxt;         // message length in bytes, wraps
  logic         end_r, end_nxt;         // message end seen, padding owed
  logic         pad80_r, pad80_nxt;     // 0x80 already shifted in
  logic         len_here_r, len_here_nxt; // length goes into this block
  logic [5:0]   rnd_r, rnd_nxt;
  logic [2:0]   oidx_r, oidx_nxt;
  word_t        hash_r [HASH_WORDS];
  word_t        hash_nxt [HASH_WORDS];
  word_t        v_r [HASH_WORDS];
  word_t        v_nxt [HASH_WORDS];
  word_t        kw_r, kw_nxt;           // K[t] + W[t] for the coming round
  logic [511:0] blk_r, blk_nxt;         // byte shift line, reused as W window

  word_t        t1, t2, w_new;
  logic [7:0]   pad_byte;
  logic [63:0]  bit_len;
  logic [5:0]   rnd_inc;

  // W window taps: word j of the block sits at bits 511-32j.
  assign w_new = small_sigma1(blk_r[511-32*14 -: 32]) + blk_r[511-32*9 -: 32]
               + small_sigma0(blk_r[511-32*1 -: 32]) + blk_r[511 -: 32];

  assign t1 = v_r[7] + big_sigma1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6]) + kw_r;
  assign t2 = big_sigma0(v_r[0]) + majority(v_r[0], v_r[1], v_r[2]);

  assign rnd_inc = rnd_r + 6'd1;
  assign bit_len = {len_r, 3'b000};

  // Byte fed in during padding: marker, zero fill, then big-endian length.
  always_comb begin
    if (!pad80_r) begin
      pad_byte = PAD_BYTE;
    end else if (len_here_r && (fill_r >= 6'(LEN_POS))) begin
      pad_byte = bit_len[63 - 8*fill_r[2:0] -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_final_word  = (oidx_r == 3'd7);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    end_nxt      = end_r;
    pad80_nxt    = pad80_r;
    len_here_nxt = len_here_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    hash_nxt     = hash_r;
    v_nxt        = v_r;
    kw_nxt       = kw_r;
    blk_nxt      = blk_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          end_nxt = in_message_end;
          if (in_byte_present) begin
            blk_nxt  = {blk_r[503:0], in_data_byte};
            fill_nxt = fill_r + 6'd1;
            len_nxt  = len_r + 61'd1;
          end
          if (in_byte_present && (fill_r == 6'd63)) begin
            state_nxt = S_PREP;
          end else if (in_message_end) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        blk_nxt  = {blk_r[503:0], pad_byte};
        fill_nxt = fill_r + 6'd1;
        if (!pad80_r) begin
          pad80_nxt    = 1'b1;
          len_here_nxt = (fill_r < 6'(LEN_POS));
        end
        if (fill_r == 6'd63) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          v_nxt[i] = hash_r[i];
        end
        kw_nxt    = ROUND_K[0] + blk_r[511 -: 32];
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        blk_nxt  = {blk_r[479:0], w_new};
        kw_nxt   = ROUND_K[rnd_inc] + blk_r[511-32 -: 32];
        rnd_nxt  = rnd_inc;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (pad80_r && len_here_r) begin
          state_nxt = S_OUT;
          oidx_nxt  = 3'd0;
        end else begin
          // marker not yet sent, or landed too late for the length: one more block
          if (pad80_r) begin
            len_here_nxt = 1'b1;
          end
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            hash_nxt     = INITIAL_H;
            len_nxt      = '0;
            fill_nxt     = '0;
            end_nxt      = 1'b0;
            pad80_nxt    = 1'b0;
            len_here_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      len_r      <= '0;
      end_r      <= 1'b0;
      pad80_r    <= 1'b0;
      len_here_r <= 1'b0;
      rnd_r      <= '0;
      oidx_r     <= '0;
      hash_r     <= INITIAL_H;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      end_r      <= end_nxt;
      pad80_r    <= pad80_nxt;
      len_here_r <= len_here_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      hash_r     <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    kw_r  <= kw_nxt;
    blk_r <= blk_nxt;
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output channels open together");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final_word |=> in_ready)
    else $error("not idle after last digest word");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words out of order");

  a_full_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> ($past(state_r) == S_ROUND) && ($past(rnd_r) == 6'd63))
    else $error("compression folded before round 63");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher: random messages, digest scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import shabs_pkg::*;

  // One expected digest word as it should appear on the result channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Scoreboard with its own SHA-256 model: absorbs every accepted input item
  // and queues the eight digest words that each message end produces.
  class digest_scoreboard;
    word_t          hash_h [HASH_WORDS];
    logic [7:0]     blk [BLOCK_BYTES];
    int             fill;
    logic [60:0]    len_bytes;   // byte count, wraps so the bit length wraps at 2^64
    digest_word_t   expected_digest [$];
    int             mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hash_h    = INITIAL_H;
      fill      = 0;
      len_bytes = '0;
    endfunction

    function word_t rotr(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t w [64];
      word_t v [HASH_WORDS];
      word_t t1;
      word_t t2;
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
        w[i] = w[i-16] + w[i-7]
             + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      v = hash_h;
      for (int i = 0; i < ROUNDS; i++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < HASH_WORDS; i++) hash_h[i] += v[i];
    endfunction

    // Note one accepted input item.
    function void absorb_item(logic [7:0] data, logic present, logic msg_end);
      logic [63:0]  bit_len;
      digest_word_t dw;
      if (present) begin
        blk[fill] = data;
        fill++;
        len_bytes = len_bytes + 61'd1;
        if (fill == BLOCK_BYTES) begin
          compress();
          fill = 0;
        end
      end
      if (!msg_end) return;
      blk[fill] = PAD_BYTE;
      fill++;
      // No room for the length: flush a block of padding first.
      if (fill > LEN_POS) begin
        for (int i = fill; i < BLOCK_BYTES; i++) blk[i] = 8'h00;
        compress();
        fill = 0;
      end
      for (int i = fill; i < LEN_POS; i++) blk[i] = 8'h00;
      bit_len = {len_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[LEN_POS + i] = bit_len[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < HASH_WORDS; i++) begin
        dw.word = hash_h[i];
        dw.idx  = 3'(i);
        dw.last = (i == HASH_WORDS - 1);
        expected_digest.push_back(dw);
      end
      restart();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Check one accepted result item against the oldest expectation.
    task check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t exp_w;
      if (expected_digest.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h idx %0d", word, idx));
        return;
      end
      exp_w = expected_digest.pop_front();
      if (word !== exp_w.word)
        report_mismatch($sformatf("word %0d: got %08h, want %08h", exp_w.idx, word, exp_w.word));
      if (idx !== exp_w.idx)
        report_mismatch($sformatf("word index: got %0d, want %0d", idx, exp_w.idx));
      if (last !== exp_w.last)
        report_mismatch($sformatf("final flag on word %0d: got %0b, want %0b",
                                  exp_w.idx, last, exp_w.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_message_end  = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;

  digest_scoreboard sb = new();

  int send_idle_pct = 0;   // chance per cycle that the sender idles
  int recv_idle_pct = 0;   // chance per cycle that the receiver stalls
  int items_sent    = 0;   // every accepted input item, noise items included
  bit hold_request  = 1'b0;

  sha256_byte_stream_hasher_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("sha256_byte_stream_hasher_top regression: fail");
    $finish;
  end

  // Offer one item, with random idle cycles in front, and hold it until taken.
  // Every assignment here happens at a rising edge, at most once per signal.
  task send_item(logic [7:0] data, logic present, logic msg_end);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_byte_present <= present;
    in_message_end  <= msg_end;
    do @(posedge clk); while (!in_ready);
    sb.absorb_item(data, present, msg_end);
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding digest word has come back.
  // Always waits for a rising edge, so valid is not driven twice in a step.
  task quiesce_sender();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_digest.size() != 0);
  endtask

  // One message of random bytes; noise items (no byte, no end) are sprinkled
  // in. The end either rides on the last byte or comes as an item of its own.
  task send_message(int len);
    bit merged;
    merged = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, merged && (i == len - 1));
    end
    if (!merged) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly short messages; some around the one/two final block boundary and
  // a few spanning more than one full block.
  function int pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 12);
      6, 7:             return $urandom_range(52, 66);
      8:                return $urandom_range(1, 40);
      default:          return $urandom_range(100, 130);
    endcase
  endfunction

  task run_random(int target);
    while (items_sent < target) send_message(pick_len());
  endtask

  // Receiver: checks every taken result item, then picks out_ready for the
  // next cycle. A requested hold-off is counted down here.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_word(out_digest_word, out_word_index, out_final_word);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc" with the end on the last byte, bytes at
    // both extremes with an ignored item between and a bare end, single-byte
    // messages, and a second empty message.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    quiesce_sender();

    // Phase 1: sender rarely idles, receiver mostly stalls. Lengths 55 and 56
    // straddle the point where padding needs a second final block.
    send_idle_pct = 6;
    recv_idle_pct = 65;
    send_message(55);
    send_message(56);
    run_random(130);
    quiesce_sender();   // sender pauses until all digest words are home

    // Phase 2: roles swapped. The receiver holds off for a long stretch while
    // a short message goes in, so the block stalls its input behind it.
    send_idle_pct = 65;
    recv_idle_pct = 6;
    hold_request  = 1'b1;
    send_message(3);
    send_message(2);
    run_random(170);

    // Phase 3: no idling at all; full-block boundary lengths first.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_message(63);
    send_message(64);
    run_random(330);

    quiesce_sender();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_digest.size() == 0) begin
      $display("sha256_byte_stream_hasher_top regression: pass");
    end else begin
      $display("sha256_byte_stream_hasher_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/shabs_pkg.sv
rtl/core/sha256_byte_stream_hasher_top.sv
sim/tb_top.sv
